>>> hw/rtl/triangle_barycentric_interpolator_core_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef TRIANGLE_BARYCENTRIC_INTERPOLATOR_CORE_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_INTERPOLATOR_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define TBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/tbi_pkg.sv
// Types and constants of the triangle barycentric interpolator.
`timescale 1ns / 1ps
package tbi_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int DW      = 33;
  localparam int PW      = 66;
  localparam int SW      = 67;
  localparam int NLO     = 34;
  localparam int NHI     = SW - NLO;
  localparam int NW      = 101;
  localparam int RW      = 102;
  localparam int AW      = SW + 2;
  localparam int QB      = 33;
  localparam int IN_W    = 384;

  localparam int GEOM_STG = 4;
  localparam int NUM_STG  = 3;
  localparam int DIV_STG  = QB + 3;
  localparam int NSTG     = GEOM_STG + NUM_STG + DIV_STG;

  typedef struct packed {
    logic                      hit;
    logic signed [SW-1:0]      den;
    logic signed [SW-1:0]      n0;
    logic signed [SW-1:0]      n1;
    logic signed [DW-1:0]      dv1;
    logic signed [DW-1:0]      dv2;
    logic signed [COORD_W-1:0] v3;
  } geom_t;

  typedef struct packed {
    logic                      hit;
    logic signed [SW-1:0]      den;
    logic signed [NW-1:0]      num;
    logic signed [COORD_W-1:0] v3;
  } numer_t;

endpackage

>>> hw/rtl/tbi_geom.sv
// Geometry stages: differences, products, sums and the hit decision.
`timescale 1ns / 1ps
module tbi_geom (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tbi_pkg::IN_W-1:0]  tdata_i,
  output tbi_pkg::geom_t            geom_o
);

  localparam int DW = tbi_pkg::DW;
  localparam int PW = tbi_pkg::PW;
  localparam int SW = tbi_pkg::SW;
  localparam int CW = tbi_pkg::COORD_W;
  localparam int RW2 = 2 * tbi_pkg::RAD_W;

  function automatic logic signed [DW-1:0] sub_ext(logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y);
    return DW'(x) - DW'(y);
  endfunction

  logic signed [CW-1:0] r1, z1, v1, r2, z2, v2, r3, z3, v3, rp, zp;
  logic [tbi_pkg::RAD_W-1:0] rad;

  assign r1  = tdata_i[31:0];
  assign z1  = tdata_i[63:32];
  assign v1  = tdata_i[95:64];
  assign r2  = tdata_i[127:96];
  assign z2  = tdata_i[159:128];
  assign v2  = tdata_i[191:160];
  assign r3  = tdata_i[223:192];
  assign z3  = tdata_i[255:224];
  assign v3  = tdata_i[287:256];
  assign rad = tdata_i[318:288];
  assign rp  = tdata_i[350:319];
  assign zp  = tdata_i[382:351];

  logic signed [DW-1:0] dr_q, dz_q, a_q, b_q, c_q, d_q, e_q, f_q, g_q;
  logic signed [DW-1:0] er0_q, ez0_q, pr3_q, ez1_q, pr1_q, pz1_q, dv1_q, dv2_q;
  logic signed [CW-1:0] v3_q;
  logic [tbi_pkg::RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q  <= sub_ext(rp, r1);
      dz_q  <= sub_ext(zp, z1);
      a_q   <= sub_ext(z2, z3);
      b_q   <= sub_ext(r1, r3);
      c_q   <= sub_ext(r3, r2);
      d_q   <= sub_ext(z1, z3);
      e_q   <= sub_ext(rp, r3);
      f_q   <= sub_ext(zp, z3);
      g_q   <= sub_ext(z3, z1);
      er0_q <= sub_ext(r2, r1);
      ez0_q <= sub_ext(z2, z1);
      pr3_q <= sub_ext(r3, r1);
      ez1_q <= sub_ext(z3, z2);
      pr1_q <= sub_ext(rp, r2);
      pz1_q <= sub_ext(zp, z2);
      dv1_q <= sub_ext(v1, v3);
      dv2_q <= sub_ext(v2, v3);
      v3_q  <= v3;
      rad_q <= rad;
    end
  end

  logic signed [PW-1:0] sdr_q, sdz_q, ab_q, cd_q, ae_q, cf_q, ge_q, bf_q, de_q;
  logic signed [PW-1:0] c0a_q, c0b_q, c1a_q, c1b_q, nra_q, nrb_q;
  logic [RW2-1:0] rad2_q;
  logic signed [DW-1:0] dv1_p_q, dv2_p_q;
  logic signed [CW-1:0] v3_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdr_q   <= dr_q * dr_q;
      sdz_q   <= dz_q * dz_q;
      rad2_q  <= rad_q * rad_q;
      ab_q    <= a_q * b_q;
      cd_q    <= c_q * d_q;
      ae_q    <= a_q * e_q;
      cf_q    <= c_q * f_q;
      ge_q    <= g_q * e_q;
      bf_q    <= b_q * f_q;
      de_q    <= d_q * e_q;
      c0a_q   <= ez0_q * dr_q;
      c0b_q   <= er0_q * dz_q;
      c1a_q   <= ez1_q * pr1_q;
      c1b_q   <= c_q * pz1_q;
      nra_q   <= ez0_q * pr3_q;
      nrb_q   <= er0_q * g_q;
      dv1_p_q <= dv1_q;
      dv2_p_q <= dv2_q;
      v3_p_q  <= v3_q;
    end
  end

  logic [SW-1:0] dist_q;
  logic [RW2-1:0] rad2_s_q;
  logic signed [SW-1:0] den_q, n0_q, n1_q, c0_q, c1_q, c2_q, nrm_q;
  logic signed [DW-1:0] dv1_s_q, dv2_s_q;
  logic signed [CW-1:0] v3_s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q   <= SW'(unsigned'(sdr_q)) + SW'(unsigned'(sdz_q));
      rad2_s_q <= rad2_q;
      den_q    <= SW'(ab_q) + SW'(cd_q);
      n0_q     <= SW'(ae_q) + SW'(cf_q);
      n1_q     <= SW'(ge_q) + SW'(bf_q);
      c0_q     <= SW'(c0a_q) - SW'(c0b_q);
      c1_q     <= SW'(c1a_q) - SW'(c1b_q);
      c2_q     <= SW'(de_q) - SW'(bf_q);
      nrm_q    <= SW'(nra_q) - SW'(nrb_q);
      dv1_s_q  <= dv1_p_q;
      dv2_s_q  <= dv2_p_q;
      v3_s_q   <= v3_p_q;
    end
  end

  logic near, on_line, same_side, hit;

  always_comb begin
    near      = dist_q < SW'(rad2_s_q);
    on_line   = (c0_q == '0) || (c1_q == '0) || (c2_q == '0);
    same_side = (nrm_q != '0) && (c0_q[SW-1] == nrm_q[SW-1]) &&
                (c1_q[SW-1] == nrm_q[SW-1]) && (c2_q[SW-1] == nrm_q[SW-1]);
    hit       = near && (den_q != '0) && (on_line || same_side);
  end

  tbi_pkg::geom_t geom_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q.hit <= hit;
      geom_q.den <= den_q;
      geom_q.n0  <= n0_q;
      geom_q.n1  <= n1_q;
      geom_q.dv1 <= dv1_s_q;
      geom_q.dv2 <= dv2_s_q;
      geom_q.v3  <= v3_s_q;
    end
  end

  assign geom_o = geom_q;

endmodule

>>> hw/rtl/tbi_numer.sv
// Numerator stages: the weighted value sum, built from split partial products.
`timescale 1ns / 1ps
module tbi_numer (
  input  logic            clk_i,
  input  logic            en_i,
  input  tbi_pkg::geom_t  geom_i,
  output tbi_pkg::numer_t numer_o
);

  localparam int DW  = tbi_pkg::DW;
  localparam int SW  = tbi_pkg::SW;
  localparam int NW  = tbi_pkg::NW;
  localparam int NLO = tbi_pkg::NLO;
  localparam int LW  = DW + NLO + 1;
  localparam int HW  = DW + tbi_pkg::NHI;

  logic signed [LW-1:0] p0lo_q, p1lo_q;
  logic signed [HW-1:0] p0hi_q, p1hi_q;
  logic                 hit_a_q;
  logic signed [SW-1:0] den_a_q;
  logic signed [tbi_pkg::COORD_W-1:0] v3_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0lo_q  <= geom_i.dv1 * $signed({1'b0, geom_i.n0[NLO-1:0]});
      p0hi_q  <= geom_i.dv1 * $signed(geom_i.n0[SW-1:NLO]);
      p1lo_q  <= geom_i.dv2 * $signed({1'b0, geom_i.n1[NLO-1:0]});
      p1hi_q  <= geom_i.dv2 * $signed(geom_i.n1[SW-1:NLO]);
      hit_a_q <= geom_i.hit;
      den_a_q <= geom_i.den;
      v3_a_q  <= geom_i.v3;
    end
  end

  logic signed [NW-1:0] p0_q, p1_q;
  logic                 hit_b_q;
  logic signed [SW-1:0] den_b_q;
  logic signed [tbi_pkg::COORD_W-1:0] v3_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= NW'(p0lo_q) + (NW'(p0hi_q) <<< NLO);
      p1_q    <= NW'(p1lo_q) + (NW'(p1hi_q) <<< NLO);
      hit_b_q <= hit_a_q;
      den_b_q <= den_a_q;
      v3_b_q  <= v3_a_q;
    end
  end

  tbi_pkg::numer_t numer_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numer_q.num <= p0_q + p1_q;
      numer_q.hit <= hit_b_q;
      numer_q.den <= den_b_q;
      numer_q.v3  <= v3_b_q;
    end
  end

  assign numer_o = numer_q;

endmodule

>>> hw/rtl/tbi_div.sv
// Rounded division, one quotient bit per stage, then offset and saturation.
`timescale 1ns / 1ps
module tbi_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  tbi_pkg::numer_t                    numer_i,
  output logic                               hit_o,
  output logic signed [tbi_pkg::COORD_W-1:0] value_o
);

  localparam int SW = tbi_pkg::SW;
  localparam int NW = tbi_pkg::NW;
  localparam int RW = tbi_pkg::RW;
  localparam int AW = tbi_pkg::AW;
  localparam int QB = tbi_pkg::QB;
  localparam int CW = tbi_pkg::COORD_W;
  localparam int XW = QB + 3;
  localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [RW-1:0]        rem;
    logic [QB-1:0]        quo;
    logic [AW-1:0]        ad2;
    logic                 ovf;
    logic                 neg;
    logic                 hit;
    logic signed [CW-1:0] v3;
  } dstep_t;

  logic [NW-1:0] anum;
  logic [SW-1:0] aden;

  always_comb begin
    anum = numer_i.num[NW-1] ? NW'(-numer_i.num) : NW'(numer_i.num);
    aden = numer_i.den[SW-1] ? SW'(-numer_i.den) : SW'(numer_i.den);
  end

  logic [RW-1:0]        an2_q;
  logic [AW-1:0]        ad2_q;
  logic                 neg_q, hit_q;
  logic signed [CW-1:0] v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an2_q <= RW'({anum, 1'b0}) + RW'(aden);
      ad2_q <= AW'({aden, 1'b0});
      neg_q <= numer_i.num[NW-1] ^ numer_i.den[SW-1];
      hit_q <= numer_i.hit;
      v3_q  <= numer_i.v3;
    end
  end

  dstep_t st_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem <= an2_q;
      st_q[0].quo <= '0;
      st_q[0].ad2 <= ad2_q;
      st_q[0].ovf <= an2_q >= (RW'(ad2_q) << QB);
      st_q[0].neg <= neg_q;
      st_q[0].hit <= hit_q;
      st_q[0].v3  <= v3_q;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] trial;
    logic          take;
    dstep_t        nxt;

    always_comb begin
      trial        = RW'(st_q[k].ad2) << BIT;
      take         = st_q[k].rem >= trial;
      nxt          = st_q[k];
      nxt.rem      = take ? st_q[k].rem - trial : st_q[k].rem;
      nxt.quo[BIT] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  logic signed [XW-1:0] sq, sum;
  logic signed [CW-1:0] res;

  always_comb begin
    sq  = st_q[QB].neg ? -$signed({3'b000, st_q[QB].quo}) : $signed({3'b000, st_q[QB].quo});
    sum = XW'(st_q[QB].v3) + sq;
    if (st_q[QB].ovf) begin
      res = st_q[QB].neg ? VMIN : VMAX;
    end else if (sum > XW'(VMAX)) begin
      res = VMAX;
    end else if (sum < XW'(VMIN)) begin
      res = VMIN;
    end else begin
      res = sum[CW-1:0];
    end
  end

  logic                 hit_o_q;
  logic signed [CW-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o_q <= st_q[QB].hit;
      value_q <= st_q[QB].hit ? res : '0;
    end
  end

  assign hit_o   = hit_o_q;
  assign value_o = value_q;

endmodule

>>> hw/rtl/triangle_barycentric_interpolator_core.sv
// Top level of the point-in-triangle barycentric interpolator.
//
// Each input transfer carries one triangle with three vertex values, a
// bounding radius around the first vertex and one grid point, all in Q16.16.
// Each input transfer yields exactly one output transfer, in order.
// The output carries the hit flag in tuser and the interpolated, saturated
// value in tdata; the value is zero when there is no hit.
// The datapath is a 43-stage pipeline: four geometry stages, three stages
// for the weighted numerator, and 36 stages for the rounded division that
// produces one quotient bit per stage.
// One item can be taken in every cycle while the skid register is empty.
// An output register and a skid register sit behind the pipeline, so a new
// item is taken while a result waits; when both hold results the whole
// pipeline holds and s_axis_tready falls until the receiver takes one.
// Reset clears all valid bits; no result is offered until new input arrives.
`timescale 1ns / 1ps
`include "triangle_barycentric_interpolator_core_macros.svh"
module triangle_barycentric_interpolator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: vertex1_r, vertex1_z, vertex1_value, vertex2_r,
  // vertex2_z, vertex2_value, vertex3_r, vertex3_z, vertex3_value,
  // bound_radius (31 bits), point_r, point_z, one zero pad bit.
  input  logic [tbi_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: value.
  output logic [tbi_pkg::COORD_W-1:0]       m_axis_tdata,
  // Fields from bit 0 up: hit.
  output logic                              m_axis_tuser
);

  localparam int NSTG = tbi_pkg::NSTG;
  localparam int CW   = tbi_pkg::COORD_W;

  logic en;
  logic [NSTG-1:0] valid_q;
  logic out_v_q, sk_v_q;
  logic out_hit_q, sk_hit_q;
  logic [CW-1:0] out_val_q, sk_val_q;

  tbi_pkg::geom_t  geom;
  tbi_pkg::numer_t numer;
  logic            pipe_hit;
  logic signed [CW-1:0] pipe_val;

  assign en = !sk_v_q;
  assign s_axis_tready = en;

  tbi_geom u_geom (
    .clk_i   (clk_i),
    .en_i    (en),
    .tdata_i (s_axis_tdata),
    .geom_o  (geom)
  );

  tbi_numer u_numer (
    .clk_i   (clk_i),
    .en_i    (en),
    .geom_i  (geom),
    .numer_o (numer)
  );

  tbi_div u_div (
    .clk_i   (clk_i),
    .en_i    (en),
    .numer_i (numer),
    .hit_o   (pipe_hit),
    .value_o (pipe_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  logic push, pop;

  assign push = en && valid_q[NSTG-1];
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || pop) begin
      out_v_q <= sk_v_q || push;
      sk_v_q  <= 1'b0;
    end else if (push) begin
      sk_v_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (sk_v_q) begin
        out_hit_q <= sk_hit_q;
        out_val_q <= sk_val_q;
      end else begin
        out_hit_q <= pipe_hit;
        out_val_q <= pipe_val;
      end
    end else if (push) begin
      sk_hit_q <= pipe_hit;
      sk_val_q <= pipe_val;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_hit_q;

  `TBI_ASSERT(a_nohit_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "miss with nonzero value")
  `TBI_ASSERT(a_skid_behind_out, sk_v_q |-> out_v_q, "skid register full while output register empty")
  `TBI_ASSERT(a_stall_holds_last, !s_axis_tready && valid_q[NSTG-1] |=> valid_q[NSTG-1], "stalled last stage lost its item")
  `TBI_ASSERT(a_accept_enters, s_axis_tvalid && s_axis_tready |=> valid_q[0], "accepted transfer did not enter the pipeline")
  `TBI_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

>>> test/triangle_barycentric_interpolator_core_tb.sv
// Self-checking testbench for the triangle barycentric interpolator core.
`timescale 1ns / 1ps
module triangle_barycentric_interpolator_core_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] r1, z1, v1, r2, z2, v2, r3, z3, v3;
    logic        [30:0] rad;
    logic signed [31:0] pr, pz;
  } tri_item_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] value;
  } interp_t;

  localparam wide_t SAT_MAX = 128'sd2147483647;
  localparam wide_t SAT_MIN = -128'sd2147483648;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        s_valid = 1'b0;
  logic [tbi_pkg::IN_W-1:0]    s_data = '0;
  logic                        m_ready = 1'b0;
  logic                        s_axis_tready;
  logic                        m_axis_tvalid;
  logic [tbi_pkg::COORD_W-1:0] m_axis_tdata;
  logic                        m_axis_tuser;

  interp_t interp_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      tx_idle = 1'b1;
  bit      rx_idle = 1'b1;
  int      rx_hold = 0;

  triangle_barycentric_interpolator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sgn(input wide_t x);
    return (x < 0) ? -1 : ((x == 0) ? 0 : 1);
  endfunction

  function automatic wide_t edge_cross(input wide_t er, input wide_t ez,
                                       input wide_t pr, input wide_t pz);
    return ez * pr - er * pz;
  endfunction

  function automatic interp_t predict_interp(input tri_item_t t);
    interp_t o;
    wide_t r1, z1, v1, r2, z2, v2, r3, z3, v3, radw, rp, zp;
    wide_t dr, dz, den, nrm, c0, c1, c2, n0, n1, num, an, ad, q, res;
    int sn;
    r1 = wide_t'(t.r1); z1 = wide_t'(t.z1); v1 = wide_t'(t.v1);
    r2 = wide_t'(t.r2); z2 = wide_t'(t.z2); v2 = wide_t'(t.v2);
    r3 = wide_t'(t.r3); z3 = wide_t'(t.z3); v3 = wide_t'(t.v3);
    radw = wide_t'(t.rad); rp = wide_t'(t.pr); zp = wide_t'(t.pz);
    o.hit = 1'b0;
    o.value = '0;
    dr = rp - r1;
    dz = zp - z1;
    if (!(dr * dr + dz * dz < radw * radw)) return o;
    den = (z2 - z3) * (r1 - r3) + (r3 - r2) * (z1 - z3);
    if (den == 0) return o;
    nrm = edge_cross(r2 - r1, z2 - z1, r3 - r1, z3 - z1);
    c0 = edge_cross(r2 - r1, z2 - z1, rp - r1, zp - z1);
    c1 = edge_cross(r3 - r2, z3 - z2, rp - r2, zp - z2);
    c2 = edge_cross(r1 - r3, z1 - z3, rp - r3, zp - z3);
    sn = sgn(nrm);
    if (!(c0 == 0 || c1 == 0 || c2 == 0 ||
          (sgn(c0) == sn && sgn(c1) == sn && sgn(c2) == sn))) return o;
    n0 = (z2 - z3) * (rp - r3) + (r3 - r2) * (zp - z3);
    n1 = (z3 - z1) * (rp - r3) + (r1 - r3) * (zp - z3);
    num = (v1 - v3) * n0 + (v2 - v3) * n1;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    if ((num < 0) != (den < 0)) q = -q;
    res = v3 + q;
    if (res > SAT_MAX) res = SAT_MAX;
    if (res < SAT_MIN) res = SAT_MIN;
    o.hit = 1'b1;
    o.value = res[31:0];
    return o;
  endfunction

  task automatic send_triangle(input tri_item_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {1'b0, t.pz, t.pr, t.rad, t.v3, t.z3, t.r3, t.v2, t.z2, t.r2,
               t.v1, t.z1, t.r1};
    do @(posedge clk_i); while (!s_axis_tready);
    interp_q.insert(interp_q.size(), predict_interp(t));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (interp_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, 32'd0);
      end else begin
        interp_t want;
        want = interp_q.pop_front();
        if (m_axis_tuser !== want.hit) begin
          report_mismatch("hit", 32'(m_axis_tuser), 32'(want.hit));
        end
        if (m_axis_tdata !== want.value) report_mismatch("value", m_axis_tdata, want.value);
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic tri_item_t full_random();
    tri_item_t t;
    t.r1 = $urandom; t.z1 = $urandom; t.v1 = $urandom;
    t.r2 = $urandom; t.z2 = $urandom; t.v2 = $urandom;
    t.r3 = $urandom; t.z3 = $urandom; t.v3 = $urandom;
    t.rad = 31'($urandom); t.pr = $urandom; t.pz = $urandom;
    return t;
  endfunction

  function automatic longint coord_near(input longint c, input longint s);
    return c + longint'($urandom_range(0, 2 * s)) - s;
  endfunction

  // A triangle of random size whose point lies inside it or on an edge line.
  function automatic tri_item_t shaped_random();
    tri_item_t t;
    longint s, cr, cz, r1, z1, r2, z2, r3, z3, a, b, c, k;
    s = longint'(1) << $urandom_range(2, 27);
    cr = coord_near(0, 1 << 27);
    cz = coord_near(0, 1 << 27);
    r1 = coord_near(cr, s); z1 = coord_near(cz, s);
    r2 = coord_near(cr, s); z2 = coord_near(cz, s);
    r3 = coord_near(cr, s); z3 = coord_near(cz, s);
    if ($urandom_range(0, 19) == 0) begin
      r3 = r1 + 2 * (r2 - r1);
      z3 = z1 + 2 * (z2 - z1);
    end
    t.r1 = 32'(r1); t.z1 = 32'(z1); t.r2 = 32'(r2); t.z2 = 32'(z2);
    t.r3 = 32'(r3); t.z3 = 32'(z3);
    if ($urandom_range(0, 3) == 0) begin
      k = longint'($urandom_range(0, 6)) - 3;
      t.pr = 32'(r1 + k * (r2 - r1));
      t.pz = 32'(z1 + k * (z2 - z1));
    end else begin
      a = longint'($urandom_range(0, 15));
      b = longint'($urandom_range(0, 15));
      c = longint'($urandom_range(1, 15));
      t.pr = 32'((a * r1 + b * r2 + c * r3) / (a + b + c));
      t.pz = 32'((a * z1 + b * z2 + c * z3) / (a + b + c));
    end
    if ($urandom_range(0, 1)) begin
      t.v1 = $urandom; t.v2 = $urandom; t.v3 = $urandom;
    end else begin
      t.v1 = 32'(coord_near(0, 1 << 20));
      t.v2 = 32'(coord_near(0, 1 << 20));
      t.v3 = 32'(coord_near(0, 1 << 20));
    end
    t.rad = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'h7FFFFFFF;
    return t;
  endfunction

  task automatic test_directed();
    tri_item_t t;
    t = '{default: '0};
    send_triangle(t);
    t.rad = 31'h7FFFFFFF;
    send_triangle(t);
    t = '{r1: 0, z1: 0, v1: 32'sh00010000, r2: 32'sh00100000, z2: 0,
          v2: 32'sh00020000, r3: 0, z3: 32'sh00100000, v3: 32'sh00030000,
          rad: 31'h7FFFFFFF, pr: 32'sh00040000, pz: 32'sh00040000};
    send_triangle(t);
    t.pr = 0; t.pz = 0;
    send_triangle(t);
    t.rad = 0;
    send_triangle(t);
    t.rad = 31'h00040000; t.pr = 32'sh00040000; t.pz = 0;
    send_triangle(t);
    t.rad = 31'h7FFFFFFF;
    send_triangle(t);
    t.pr = 32'sh00300000; t.pz = 0;
    send_triangle(t);
    t.pr = -32'sh00300000; t.pz = 32'sh00400000;
    send_triangle(t);
    t.pr = 32'sh00200000; t.pz = 32'sh00200000;
    send_triangle(t);
    t.v1 = 32'sh7FFFFFFF; t.v2 = 32'sh80000000; t.v3 = 32'sh7FFFFFFF;
    t.pr = 32'sh00F00000; t.pz = 0;
    send_triangle(t);
    t.pr = -32'sh00F00000;
    send_triangle(t);
    t.r2 = t.r1; t.z2 = t.z1;
    send_triangle(t);
    t = '{r1: 32'sh80000000, z1: 32'sh80000000, v1: 32'sh80000000,
          r2: 32'sh7FFFFFFF, z2: 32'sh80000000, v2: 32'sh7FFFFFFF,
          r3: 32'sh80000000, z3: 32'sh7FFFFFFF, v3: 32'sh80000000,
          rad: 31'h7FFFFFFF, pr: 32'sh80000000, pz: 32'sh80000000};
    send_triangle(t);
    t.pr = 32'sh7FFFFFFF; t.pz = 32'sh7FFFFFFF;
    send_triangle(t);
    t.pr = 32'sh80010000; t.pz = 32'sh80010000;
    send_triangle(t);
    t = '{default: '1};
    t.rad = 31'h7FFFFFFF;
    send_triangle(t);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      send_triangle(($urandom_range(0, 3) == 0) ? full_random() : shaped_random());
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 300;
    for (int i = 0; i < 80; i++) send_triangle(shaped_random());
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_triangle(shaped_random());
    s_valid <= 1'b0;
    wait (interp_q.size() == 0);
    for (int i = 0; i < 20; i++) send_triangle(shaped_random());
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(1100);
    s_valid <= 1'b0;
    wait (interp_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
